// ----- rtl/olist_pkg.sv -----
package olist_pkg;

   localparam int unsigned OLIST_DEPTH       = 16;
   localparam int unsigned OLIST_VALUE_WIDTH = 32;

   // field widths of the stream payloads
   localparam int unsigned REQ_OP_WIDTH    = 3;
   localparam int unsigned REQ_POS_WIDTH   = 16;
   localparam int unsigned REQ_VALUE_WIDTH = 32;
   localparam int unsigned RSP_STAT_WIDTH  = 3;
   localparam int unsigned RSP_COUNT_WIDTH = 5;

   // request kinds
   localparam logic [REQ_OP_WIDTH-1:0] OP_INS_POS  = 3'd0;
   localparam logic [REQ_OP_WIDTH-1:0] OP_INS_HEAD = 3'd1;
   localparam logic [REQ_OP_WIDTH-1:0] OP_APPEND   = 3'd2;
   localparam logic [REQ_OP_WIDTH-1:0] OP_DELETE   = 3'd3;
   localparam logic [REQ_OP_WIDTH-1:0] OP_SEARCH   = 3'd4;

   // response status codes
   localparam logic [RSP_STAT_WIDTH-1:0] ST_OK       = 3'd0;
   localparam logic [RSP_STAT_WIDTH-1:0] ST_BADPOS   = 3'd1;
   localparam logic [RSP_STAT_WIDTH-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [RSP_STAT_WIDTH-1:0] ST_EMPTY    = 3'd3;
   localparam logic [RSP_STAT_WIDTH-1:0] ST_FULL     = 3'd4;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic capture;   // register the compare result against the incoming value
      logic insert;    // open a slot at ins_pos and write the value there
      logic remove;    // close the slot of the first matching entry
   } olist_ctl_type;

endpackage

// ----- rtl/ordered_list_engine.sv -----
// Ordered list engine: a chain of DEPTH cells, one list entry per cell, head at cell 0.
// Sequence: a request is accepted in S_IDLE, where every cell captures its compare result;
//   the operation is then applied and its result registered in S_EXEC.
// No new request is taken until S_EXEC has finished with the previous one. Every cell compares
//   in the accept cycle and shifts in the execute cycle, so the cost of an operation does not
//   depend on DEPTH or entry count. An unread response holds the execute cycle and so the next request.
// Reset (synchronous, active high) empties the list and drops any pending result;
//   entry storage is not cleared, only the count.
module ordered_list_engine #(
   parameter int unsigned DEPTH       = olist_pkg::OLIST_DEPTH,
   parameter int unsigned VALUE_WIDTH = olist_pkg::OLIST_VALUE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] position (signed), [47:16] value (unsigned)
   input  logic [2:0]  req_tuser,   // [2:0] op
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] status, [3] found, [8:4] count, [15:9] zero
);
   import olist_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic {
      S_IDLE,   // waiting for a request; cells capture compare results on accept
      S_EXEC    // apply the operation once the response register is free
   } state_type;

   state_type                 state_ff, state_in;
   logic [REQ_OP_WIDTH-1:0]   op_ff, op_in;
   logic [REQ_POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0]    value_ff, value_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_STAT_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [RSP_COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic                      req_fire;
   logic                      rsp_free;
   logic [VALUE_WIDTH-1:0]    req_value;
   olist_ctl_type             ctl;
   logic [CW-1:0]             ins_pos;
   logic                      any_match;
   logic                      is_full;
   logic                      is_empty;
   logic                      pos_bad;

   // chain wiring between neighboring cells
   logic [VALUE_WIDTH-1:0]    entry_w [DEPTH];
   logic [DEPTH:0]            seen_w;

   // request value, kept on its low VALUE_WIDTH bits (zero-extended if wider)
   generate
      if (VALUE_WIDTH <= REQ_VALUE_WIDTH) begin : g_val_trunc
         assign req_value = req_tdata[16 +: VALUE_WIDTH];
      end else begin : g_val_ext
         assign req_value = {{(VALUE_WIDTH - REQ_VALUE_WIDTH){1'b0}}, req_tdata[47:16]};
      end
   endgenerate

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign any_match = seen_w[DEPTH];
   assign is_full   = (count_ff == FULL_COUNT);
   assign is_empty  = (count_ff == '0);
   // negative, or beyond the current count
   assign pos_bad   = pos_ff[REQ_POS_WIDTH-1] ||
                      (pos_ff > REQ_POS_WIDTH'(count_ff));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      ctl           = '0;
      ins_pos       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in       = req_tuser;
               pos_in      = req_tdata[15:0];
               value_in    = req_value;
               ctl.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               rsp_status_in = ST_OK;
               rsp_found_in  = 1'b0;
               case (op_ff)
                  OP_INS_POS: begin
                     ins_pos = pos_ff[CW-1:0];
                     if (pos_bad) begin
                        rsp_status_in = ST_BADPOS;
                     end else if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.insert = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  OP_INS_HEAD: begin
                     ins_pos = '0;
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.insert = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  OP_APPEND: begin
                     ins_pos = count_ff;
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.insert = 1'b1;
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  OP_DELETE: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (!any_match) begin
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        ctl.remove = 1'b1;
                        count_in   = count_ff - CW'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (any_match) begin
                        rsp_found_in = 1'b1;
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
                  default: begin
                     // unused kinds: answer ok, list untouched
                  end
               endcase
               rsp_count_in = RSP_COUNT_WIDTH'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // cell chain: inserts shift right from the left neighbor, deletes pull from the right
   assign seen_w[0] = 1'b0;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [VALUE_WIDTH-1:0] left_entry;
         logic [VALUE_WIDTH-1:0] right_entry;

         if (i == 0) begin : g_head
            assign left_entry = '0;
         end else begin : g_mid_l
            assign left_entry = entry_w[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_entry = '0;
         end else begin : g_mid_r
            assign right_entry = entry_w[i+1];
         end

         olist_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .INDEX       (i)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .cmp_value   (req_value),
            .wr_value    (value_ff),
            .count       (count_ff),
            .ins_pos     (ins_pos),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .seen_in     (seen_w[i]),
            .seen_out    (seen_w[i+1]),
            .entry       (entry_w[i])
         );
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_found_ff, rsp_status_ff};

endmodule

// ----- rtl/olist_cell.sv -----
module olist_cell #(
   parameter int unsigned DEPTH       = olist_pkg::OLIST_DEPTH,
   parameter int unsigned VALUE_WIDTH = olist_pkg::OLIST_VALUE_WIDTH,
   parameter int unsigned INDEX       = 0,
   localparam int unsigned CW         = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  olist_pkg::olist_ctl_type   ctl,
   input  logic [VALUE_WIDTH-1:0]     cmp_value,
   input  logic [VALUE_WIDTH-1:0]     wr_value,
   input  logic [CW-1:0]              count,
   input  logic [CW-1:0]              ins_pos,
   input  logic [VALUE_WIDTH-1:0]     left_entry,
   input  logic [VALUE_WIDTH-1:0]     right_entry,
   input  logic                       seen_in,
   output logic                       seen_out,
   output logic [VALUE_WIDTH-1:0]     entry
);
   import olist_pkg::*;

   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                   match_ff, match_in;

   // match only counts for live entries
   assign match_in = (entry_ff == cmp_value) && (MY_INDEX < count);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (MY_INDEX > ins_pos) begin
            entry_in = left_entry;
         end else if (MY_INDEX == ins_pos) begin
            entry_in = wr_value;
         end
      end else if (ctl.remove && (seen_in || match_ff)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.capture) begin
         match_ff <= match_in;
      end
   end

   // running "a match sits at or left of here"
   assign seen_out = seen_in | match_ff;
   assign entry    = entry_ff;

endmodule
